>>> src/scrs_pkg.sv
// Shared constants, status codes and controller/datapath interface types
// for the seeded card runout shuffler. No dependencies.
package scrs_pkg;

   localparam int DECK_CARDS_DEF  = 52;
   localparam int MAX_RUNOUTS_DEF = 8;
   localparam int MAX_DEAL_DEF    = 5;

   localparam int BOARD_W  = 52;
   localparam int SEED_W   = 31;
   localparam int DEAL_W   = 3;
   localparam int CARD_W   = 6;
   localparam int RUNNUM_W = 3;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 4;
   localparam int MODBIT_W = 5;

   localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
   localparam logic [SEED_W-1:0] LCG_ADD    = 31'd12345;
   localparam logic [SEED_W-1:0] RUN_STRIDE = 31'd123456789;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEAL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUST = 2'd2;

   localparam logic [CFG_W-1:0] RUNOUT_RESET = 4'd2;

   typedef struct packed {
      logic capture;
      logic build_step;
      logic run_init;
      logic lcg_step;
      logic mod_step;
      logic rd_i;
      logic rd_j;
      logic wr_i;
      logic wr_j;
      logic deal_rd;
      logic deal_or;
      logic emit_ok;
      logic emit_err;
      logic next_run;
   } scrs_cmd_type;

   typedef struct packed {
      logic deal_too_big;
      logic deck_short;
      logic build_last;
      logic count_lt2;
      logic mod_last;
      logic i_is_one;
      logic deal_zero;
      logic deal_done;
      logic last_run;
      logic out_free;
   } scrs_sts_type;

endpackage

>>> src/scrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scrs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/scrs_ctrl.sv
// Sequencing state machine: deck build, per-step LCG, modulo and swap, deal, emit.
// Depends on scrs_pkg.
module scrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  scrs_pkg::scrs_sts_type sts,
   output scrs_pkg::scrs_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_BUILD = 4'd2;
   localparam logic [3:0] S_BCHK  = 4'd3;
   localparam logic [3:0] S_RSEED = 4'd4;
   localparam logic [3:0] S_LCG   = 4'd5;
   localparam logic [3:0] S_MOD   = 4'd6;
   localparam logic [3:0] S_RDI   = 4'd7;
   localparam logic [3:0] S_RDJ   = 4'd8;
   localparam logic [3:0] S_WRI   = 4'd9;
   localparam logic [3:0] S_WRJ   = 4'd10;
   localparam logic [3:0] S_DRD   = 4'd11;
   localparam logic [3:0] S_DOR   = 4'd12;
   localparam logic [3:0] S_EMIT  = 4'd13;
   localparam logic [3:0] S_ERR   = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = sts.deal_too_big ? S_ERR : S_BUILD;
         end
         S_BUILD: begin
            cmd.build_step = 1'b1;
            if (sts.build_last) begin
               state_in = S_BCHK;
            end
         end
         S_BCHK: begin
            state_in = sts.deck_short ? S_ERR : S_RSEED;
         end
         S_RSEED: begin
            cmd.run_init = 1'b1;
            if (!sts.count_lt2) begin
               state_in = S_LCG;
            end else begin
               state_in = sts.deal_zero ? S_EMIT : S_DRD;
            end
         end
         S_LCG: begin
            cmd.lcg_step = 1'b1;
            state_in     = S_MOD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = S_RDI;
            end
         end
         S_RDI: begin
            cmd.rd_i = 1'b1;
            state_in = S_RDJ;
         end
         S_RDJ: begin
            cmd.rd_j = 1'b1;
            state_in = S_WRI;
         end
         S_WRI: begin
            cmd.wr_i = 1'b1;
            state_in = S_WRJ;
         end
         S_WRJ: begin
            cmd.wr_j = 1'b1;
            if (!sts.i_is_one) begin
               state_in = S_LCG;
            end else begin
               state_in = sts.deal_zero ? S_EMIT : S_DRD;
            end
         end
         S_DRD: begin
            cmd.deal_rd = 1'b1;
            state_in    = S_DOR;
         end
         S_DOR: begin
            cmd.deal_or = 1'b1;
            state_in    = sts.deal_done ? S_EMIT : S_DRD;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_ok = 1'b1;
               if (sts.last_run) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_run = 1'b1;
                  state_in     = S_RSEED;
               end
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> src/scrs_dpath.sv
// Datapath: request registers, deck RAM, LCG, bit-serial modulo, board
// accumulator and result register. Depends on scrs_pkg and scrs_ram.
module scrs_dpath #(
   parameter int DECK_CARDS  = scrs_pkg::DECK_CARDS_DEF,
   parameter int MAX_RUNOUTS = scrs_pkg::MAX_RUNOUTS_DEF,
   parameter int MAX_DEAL    = scrs_pkg::MAX_DEAL_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  scrs_pkg::scrs_cmd_type           cmd,
   output scrs_pkg::scrs_sts_type           sts,
   input  logic [scrs_pkg::BOARD_W-1:0]    req_base_board,
   input  logic [scrs_pkg::BOARD_W-1:0]    req_dead_mask,
   input  logic [scrs_pkg::SEED_W-1:0]     req_shuffle_seed,
   input  logic [scrs_pkg::DEAL_W-1:0]     req_deal_count,
   input  logic                            csr_write,
   input  logic [scrs_pkg::CFG_W-1:0]      csr_runout_count,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [scrs_pkg::BOARD_W-1:0]    rsp_board_out,
   output logic [scrs_pkg::RUNNUM_W-1:0]   rsp_runout_number,
   output logic                            rsp_last_of_run,
   output logic [scrs_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int ADDR_W = $clog2(DECK_CARDS);
   localparam int CNT_W  = $clog2(DECK_CARDS + 1);
   localparam int CMP_W  = (CNT_W > scrs_pkg::DEAL_W) ? CNT_W : scrs_pkg::DEAL_W;

   logic [scrs_pkg::CFG_W-1:0]    cfg_ff;
   logic [scrs_pkg::CFG_W-1:0]    runs_ff, runs_in;
   logic [scrs_pkg::CFG_W-1:0]    run_ff;
   logic [scrs_pkg::BOARD_W-1:0]  base_ff;
   logic [scrs_pkg::BOARD_W-1:0]  occ_ff;
   logic [scrs_pkg::SEED_W-1:0]   run_seed_ff;
   logic [scrs_pkg::DEAL_W-1:0]   deal_ff;
   logic [ADDR_W-1:0]             idx_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              i_ff;
   logic [scrs_pkg::SEED_W-1:0]   lcg_ff, lcg_in;
   logic [scrs_pkg::SEED_W-1:0]   dvd_ff;
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic [CNT_W:0]                trial;
   logic [CNT_W-1:0]              divisor;
   logic [scrs_pkg::MODBIT_W-1:0] bit_ff;
   logic [scrs_pkg::CARD_W-1:0]   tmp_i_ff;
   logic [scrs_pkg::DEAL_W-1:0]   c_ff;
   logic [scrs_pkg::BOARD_W-1:0]  board_ff;
   logic                          card_free;
   logic [scrs_pkg::CARD_W-1:0]   card;

   logic                          rsp_valid_ff;
   logic [scrs_pkg::BOARD_W-1:0]  rsp_board_ff;
   logic [scrs_pkg::RUNNUM_W-1:0] rsp_num_ff;
   logic                          rsp_last_ff;
   logic [scrs_pkg::STATUS_W-1:0] rsp_status_ff;

   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [scrs_pkg::CARD_W-1:0]   ram_wr_data;
   logic                          ram_rd_en;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [scrs_pkg::CARD_W-1:0]   ram_rd_data;

   // clamp the runout count
   always_comb begin
      if (cfg_ff == '0) begin
         runs_in = scrs_pkg::CFG_W'(1);
      end else if (int'(cfg_ff) > MAX_RUNOUTS) begin
         runs_in = scrs_pkg::CFG_W'(MAX_RUNOUTS);
      end else begin
         runs_in = cfg_ff;
      end
   end

   assign card      = scrs_pkg::CARD_W'(idx_ff);
   assign card_free = (card >= scrs_pkg::CARD_W'(scrs_pkg::BOARD_W)) ? 1'b1 : !occ_ff[card];
   assign lcg_in    = scrs_pkg::SEED_W'(lcg_ff * scrs_pkg::LCG_MUL + scrs_pkg::LCG_ADD);
   assign divisor   = i_ff + CNT_W'(1);
   assign trial     = {rem_ff, dvd_ff[scrs_pkg::SEED_W-1]};
   assign rem_in    = (trial >= {1'b0, divisor}) ? CNT_W'(trial - {1'b0, divisor})
                                                 : trial[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= scrs_pkg::RUNOUT_RESET;
      end else if (csr_write) begin
         cfg_ff <= csr_runout_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         base_ff     <= req_base_board;
         occ_ff      <= req_base_board | req_dead_mask;
         run_seed_ff <= req_shuffle_seed;
         deal_ff     <= req_deal_count;
         runs_ff     <= runs_in;
         run_ff      <= '0;
         idx_ff      <= '0;
         count_ff    <= '0;
      end
      if (cmd.build_step) begin
         idx_ff <= idx_ff + ADDR_W'(1);
         if (card_free) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
      if (cmd.run_init) begin
         lcg_ff   <= run_seed_ff;
         i_ff     <= count_ff - CNT_W'(1);
         board_ff <= base_ff;
         c_ff     <= '0;
      end
      if (cmd.lcg_step) begin
         lcg_ff <= lcg_in;
         dvd_ff <= lcg_in;
         rem_ff <= '0;
         bit_ff <= scrs_pkg::MODBIT_W'(scrs_pkg::SEED_W - 1);
      end
      if (cmd.mod_step) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_ff << 1;
         bit_ff <= bit_ff - scrs_pkg::MODBIT_W'(1);
      end
      if (cmd.rd_j) begin
         tmp_i_ff <= ram_rd_data;
      end
      if (cmd.wr_j) begin
         i_ff <= i_ff - CNT_W'(1);
      end
      if (cmd.deal_or) begin
         board_ff <= board_ff | (scrs_pkg::BOARD_W'(1) << ram_rd_data);
         c_ff     <= c_ff + scrs_pkg::DEAL_W'(1);
      end
      if (cmd.next_run) begin
         run_ff      <= run_ff + scrs_pkg::CFG_W'(1);
         run_seed_ff <= run_seed_ff + scrs_pkg::RUN_STRIDE;
      end
   end

   // deck RAM port steering
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[ADDR_W-1:0];
      ram_wr_data = card;
      if (cmd.build_step) begin
         ram_wr_en = card_free;
      end else if (cmd.wr_i) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = i_ff[ADDR_W-1:0];
         ram_wr_data = ram_rd_data;
      end else if (cmd.wr_j) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = rem_ff[ADDR_W-1:0];
         ram_wr_data = tmp_i_ff;
      end
   end

   always_comb begin
      ram_rd_en   = cmd.rd_i | cmd.rd_j | cmd.deal_rd;
      ram_rd_addr = i_ff[ADDR_W-1:0];
      if (cmd.rd_j) begin
         ram_rd_addr = rem_ff[ADDR_W-1:0];
      end else if (cmd.deal_rd) begin
         ram_rd_addr = ADDR_W'(c_ff);
      end
   end

   scrs_ram #(
      .WIDTH (scrs_pkg::CARD_W),
      .DEPTH (DECK_CARDS)
   ) u_deck (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_ok || cmd.emit_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ok) begin
         rsp_board_ff  <= board_ff;
         rsp_num_ff    <= run_ff[scrs_pkg::RUNNUM_W-1:0];
         rsp_last_ff   <= sts.last_run;
         rsp_status_ff <= scrs_pkg::STATUS_OK;
      end else if (cmd.emit_err) begin
         rsp_board_ff  <= '0;
         rsp_num_ff    <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= sts.deal_too_big ? scrs_pkg::STATUS_DEAL
                                           : scrs_pkg::STATUS_EXHAUST;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_board_out     = rsp_board_ff;
   assign rsp_runout_number = rsp_num_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

   assign sts.deal_too_big = {1'b0, deal_ff} > 4'(MAX_DEAL);
   assign sts.deck_short   = CMP_W'(count_ff) < CMP_W'(deal_ff);
   assign sts.build_last   = idx_ff == ADDR_W'(DECK_CARDS - 1);
   assign sts.count_lt2    = count_ff < CNT_W'(2);
   assign sts.mod_last     = bit_ff == '0;
   assign sts.i_is_one     = i_ff == CNT_W'(1);
   assign sts.deal_zero    = deal_ff == '0;
   assign sts.deal_done    = (c_ff + scrs_pkg::DEAL_W'(1)) == deal_ff;
   assign sts.last_run     = (run_ff + scrs_pkg::CFG_W'(1)) == runs_ff;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

>>> src/seeded_card_runout_shuffler_unit.sv
// The deck is rebuilt first, then each runout is shuffled and dealt, and output stalls
// add to the run time. The 31-step serial modulo per swap sets most of it.
// One request at a time; a new one is taken as soon as the last result is registered.
// Synchronous active-high reset clears the controller, the result valid and sets
// runout_count to 2; deck contents are undefined until rebuilt.
module seeded_card_runout_shuffler_unit #(
   parameter int DECK_CARDS  = scrs_pkg::DECK_CARDS_DEF,
   parameter int MAX_RUNOUTS = scrs_pkg::MAX_RUNOUTS_DEF,
   parameter int MAX_DEAL    = scrs_pkg::MAX_DEAL_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [scrs_pkg::BOARD_W-1:0]    req_base_board,
   input  logic [scrs_pkg::BOARD_W-1:0]    req_dead_mask,
   input  logic [scrs_pkg::SEED_W-1:0]     req_shuffle_seed,
   input  logic [scrs_pkg::DEAL_W-1:0]     req_deal_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [scrs_pkg::BOARD_W-1:0]    rsp_board_out,
   output logic [scrs_pkg::RUNNUM_W-1:0]   rsp_runout_number,
   output logic                            rsp_last_of_run,
   output logic [scrs_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [scrs_pkg::CFG_W-1:0]      csr_runout_count
);

   scrs_pkg::scrs_cmd_type cmd;
   scrs_pkg::scrs_sts_type sts;

   assign csr_ready = !reset;

   scrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   scrs_dpath #(
      .DECK_CARDS  (DECK_CARDS),
      .MAX_RUNOUTS (MAX_RUNOUTS),
      .MAX_DEAL    (MAX_DEAL)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_base_board    (req_base_board),
      .req_dead_mask     (req_dead_mask),
      .req_shuffle_seed  (req_shuffle_seed),
      .req_deal_count    (req_deal_count),
      .csr_write         (csr_valid & csr_ready),
      .csr_runout_count  (csr_runout_count),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_board_out     (rsp_board_out),
      .rsp_runout_number (rsp_runout_number),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_status        (rsp_status)
   );

endmodule

>>> src/scrs_checker.sv
// Port-level checks for the shuffler top level, attached by bind.
// Depends on scrs_pkg and seeded_card_runout_shuffler_unit.
module scrs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [scrs_pkg::BOARD_W-1:0]  rsp_board_out,
   input logic [scrs_pkg::RUNNUM_W-1:0] rsp_runout_number,
   input logic                          rsp_last_of_run,
   input logic [scrs_pkg::STATUS_W-1:0] rsp_status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_board_out)
         && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != scrs_pkg::STATUS_OK |->
         rsp_board_out == '0 && rsp_runout_number == '0 && rsp_last_of_run
         && (rsp_status == scrs_pkg::STATUS_DEAL || rsp_status == scrs_pkg::STATUS_EXHAUST))
      else $error("malformed error result");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind seeded_card_runout_shuffler_unit scrs_checker u_scrs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_board_out     (rsp_board_out),
   .rsp_runout_number (rsp_runout_number),
   .rsp_last_of_run   (rsp_last_of_run),
   .rsp_status        (rsp_status)
);

>>> bench/seeded_card_runout_shuffler_unit_tb.sv
// Self-checking bench for seeded_card_runout_shuffler_unit: predicts every runout board
// from each accepted request and compares results in order. Depends on scrs_pkg and the DUT.
module seeded_card_runout_shuffler_unit_tb;

   localparam int QUIET_LIMIT = 30000;
   localparam int HOLDOFF_CYCLES = 3000;
   localparam int HOLDOFF_AFTER = 40;
   localparam int PHASE_ITEMS = 23;

   typedef struct packed {
      logic [scrs_pkg::BOARD_W-1:0] base;
      logic [scrs_pkg::BOARD_W-1:0] dead;
      logic [scrs_pkg::SEED_W-1:0]  seed;
      logic [scrs_pkg::DEAL_W-1:0]  deal;
   } deal_req_type;

   typedef struct packed {
      logic [scrs_pkg::BOARD_W-1:0]  board;
      logic [scrs_pkg::RUNNUM_W-1:0] num;
      logic                          last;
      logic [scrs_pkg::STATUS_W-1:0] status;
   } runout_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [scrs_pkg::BOARD_W-1:0] req_base_board = '0;
   logic [scrs_pkg::BOARD_W-1:0] req_dead_mask = '0;
   logic [scrs_pkg::SEED_W-1:0] req_shuffle_seed = '0;
   logic [scrs_pkg::DEAL_W-1:0] req_deal_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [scrs_pkg::BOARD_W-1:0] rsp_board_out;
   logic [scrs_pkg::RUNNUM_W-1:0] rsp_runout_number;
   logic rsp_last_of_run;
   logic [scrs_pkg::STATUS_W-1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [scrs_pkg::CFG_W-1:0] csr_runout_count = '0;

   deal_req_type pending_reqs[$];
   runout_type expected_runouts[$];

   logic [scrs_pkg::CARD_W-1:0] deck_copy [scrs_pkg::DECK_CARDS_DEF];
   int deck_len = 0;
   longint unsigned gen_value = 0;
   int unsigned runs_setting = int'(scrs_pkg::RUNOUT_RESET);

   int mismatches = 0;
   int requests_taken = 0;
   int runouts_checked = 0;
   int error_results = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   seeded_card_runout_shuffler_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_base_board(req_base_board),
      .req_dead_mask(req_dead_mask),
      .req_shuffle_seed(req_shuffle_seed),
      .req_deal_count(req_deal_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_board_out(rsp_board_out),
      .rsp_runout_number(rsp_runout_number),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_runout_count(csr_runout_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [scrs_pkg::BOARD_W-1:0] rand52();
      return scrs_pkg::BOARD_W'({$urandom(), $urandom()});
   endfunction

   // Leave exactly free_n cards out of both masks; split the rest between base and dead.
   function automatic deal_req_type draft_request(int free_n,
                                                  logic [scrs_pkg::DEAL_W-1:0] deal);
      logic [scrs_pkg::BOARD_W-1:0] taken;
      logic [scrs_pkg::BOARD_W-1:0] split;
      logic [scrs_pkg::BOARD_W-1:0] extra;
      int pos;
      int k;
      deal_req_type rq;
      taken = '1;
      for (k = 0; k < free_n; k++) begin
         pos = $urandom_range(0, scrs_pkg::BOARD_W - 1);
         while (!taken[pos]) pos = $urandom_range(0, scrs_pkg::BOARD_W - 1);
         taken[pos] = 1'b0;
      end
      split = rand52();
      extra = rand52();
      rq.base = taken & split;
      rq.dead = taken & (~split | extra);
      rq.seed = scrs_pkg::SEED_W'($urandom());
      rq.deal = deal;
      return rq;
   endfunction

   function automatic void deal_runouts(deal_req_type rq);
      int runs;
      int r;
      int i;
      int c;
      int j;
      logic [scrs_pkg::CARD_W-1:0] t;
      logic [scrs_pkg::BOARD_W-1:0] board;
      runout_type res;
      res.board = '0;
      res.num = '0;
      res.last = 1'b1;
      if (rq.deal > scrs_pkg::MAX_DEAL_DEF) begin
         res.status = scrs_pkg::STATUS_DEAL;
         expected_runouts.push_back(res);
         return;
      end
      runs = runs_setting;
      if (runs < 1) runs = 1;
      if (runs > scrs_pkg::MAX_RUNOUTS_DEF) runs = scrs_pkg::MAX_RUNOUTS_DEF;
      deck_len = 0;
      for (c = 0; c < scrs_pkg::DECK_CARDS_DEF; c++) begin
         if (!(rq.base[c] || rq.dead[c])) begin
            deck_copy[deck_len] = scrs_pkg::CARD_W'(c);
            deck_len++;
         end
      end
      if (deck_len < int'(rq.deal)) begin
         res.status = scrs_pkg::STATUS_EXHAUST;
         expected_runouts.push_back(res);
         return;
      end
      for (r = 0; r < runs; r++) begin
         gen_value = (64'(rq.seed) + 64'(r) * 64'(scrs_pkg::RUN_STRIDE)) & 64'h7FFF_FFFF;
         for (i = deck_len - 1; i > 0; i--) begin
            gen_value = (gen_value * 64'(scrs_pkg::LCG_MUL) + 64'(scrs_pkg::LCG_ADD))
                        & 64'h7FFF_FFFF;
            j = int'(gen_value % 64'(i + 1));
            t = deck_copy[i];
            deck_copy[i] = deck_copy[j];
            deck_copy[j] = t;
         end
         board = rq.base;
         for (c = 0; c < int'(rq.deal); c++) board[deck_copy[c]] = 1'b1;
         res.board = board;
         res.num = scrs_pkg::RUNNUM_W'(r);
         res.last = (r == runs - 1);
         res.status = scrs_pkg::STATUS_OK;
         expected_runouts.push_back(res);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < 40)
         $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic set_runout_count(logic [scrs_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_runout_count <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_runouts();
      while (pending_reqs.size() != 0 || req_valid || expected_runouts.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin : req_driver
      static int burst_left = 4;
      static int gap_left = 0;
      deal_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            req_base_board <= nxt.base;
            req_dead_mask <= nxt.dead;
            req_shuffle_seed <= nxt.seed;
            req_deal_count <= nxt.deal;
            req_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall pattern that changes mode, plus one long hold-off.
   always @(posedge clock) begin : rsp_receiver
      static int hold_left = 0;
      static bit holdoff_done = 1'b0;
      static int stall_mode = 0;
      static int mode_left = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!holdoff_done && requests_taken >= HOLDOFF_AFTER) begin
            hold_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(32, 256);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      runout_type want;
      deal_req_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            runs_setting = int'(csr_runout_count);
            csr_writes <= csr_writes + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_runouts.size() == 0) begin
               report_mismatch("result with nothing outstanding, board_out",
                               64'(rsp_board_out), 64'h0);
            end else begin
               want = expected_runouts.pop_front();
               if (rsp_board_out !== want.board)
                  report_mismatch("board_out", 64'(rsp_board_out), 64'(want.board));
               if (rsp_runout_number !== want.num)
                  report_mismatch("runout_number", 64'(rsp_runout_number), 64'(want.num));
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last_of_run", 64'(rsp_last_of_run), 64'(want.last));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (want.status != scrs_pkg::STATUS_OK) error_results <= error_results + 1;
               runouts_checked <= runouts_checked + 1;
            end
         end
         if (req_valid && req_ready) begin
            seen.base = req_base_board;
            seen.dead = req_dead_mask;
            seen.seed = req_shuffle_seed;
            seen.deal = req_deal_count;
            deal_runouts(seen);
            requests_taken <= requests_taken + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      int unsigned phase_runs[6];
      int p;
      int n;
      int size_pick;
      int free_n;
      logic [scrs_pkg::DEAL_W-1:0] deal;
      deal_req_type rq;
      phase_runs = '{15, 0, 1, 5, 2, 2};
      phase_runs[4] = $urandom_range(3, 7);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_runout_count(scrs_pkg::CFG_W'(scrs_pkg::MAX_RUNOUTS_DEF));
      @(negedge clock);

      // full deck, zero seed, largest legal deal
      rq = draft_request(52, 3'd5);
      rq.seed = '0;
      pending_reqs.push_back(rq);
      rq = draft_request(52, 3'd0);
      rq.seed = '1;
      pending_reqs.push_back(rq);
      // empty deck: nothing to deal, then one card short
      rq.base = '1; rq.dead = '0; rq.seed = 31'd123; rq.deal = 3'd0;
      pending_reqs.push_back(rq);
      rq.base = '1; rq.dead = '1; rq.deal = 3'd1;
      pending_reqs.push_back(rq);
      rq.base = '0; rq.dead = '1; rq.deal = 3'd0;
      pending_reqs.push_back(rq);
      // complementary masks
      rq.base = {13{4'hA}}; rq.dead = {13{4'h5}}; rq.deal = 3'd0;
      pending_reqs.push_back(rq);
      rq.base = {13{4'h5}}; rq.dead = '0; rq.seed = 31'd1; rq.deal = 3'd3;
      pending_reqs.push_back(rq);
      // deal count too large
      pending_reqs.push_back(draft_request(10, 3'd6));
      pending_reqs.push_back(draft_request(52, 3'd7));
      // tiny decks: no swap, one swap, exact fit, one short
      pending_reqs.push_back(draft_request(1, 3'd1));
      pending_reqs.push_back(draft_request(2, 3'd2));
      pending_reqs.push_back(draft_request(5, 3'd5));
      pending_reqs.push_back(draft_request(4, 3'd5));
      rq = draft_request(3, 3'd3);
      rq.seed = '1;
      pending_reqs.push_back(rq);
      drain_runouts();

      for (p = 0; p < 6; p++) begin
         set_runout_count(scrs_pkg::CFG_W'(phase_runs[p]));
         @(negedge clock);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            size_pick = $urandom_range(0, 99);
            if (size_pick < 8) free_n = 52;
            else if (size_pick < 20) free_n = $urandom_range(13, 51);
            else free_n = $urandom_range(0, 12);
            deal = ($urandom_range(0, 99) < 85) ? scrs_pkg::DEAL_W'($urandom_range(0, 5))
                                                : scrs_pkg::DEAL_W'($urandom_range(6, 7));
            pending_reqs.push_back(draft_request(free_n, deal));
         end
         drain_runouts();
      end

      repeat (300) @(posedge clock);
      while (expected_runouts.size() != 0) begin
         void'(expected_runouts.pop_front());
         report_mismatch("runout never delivered, outstanding count", 64'h1, 64'h0);
      end
      $display("covered %0d requests and %0d runouts (%0d error results)",
               requests_taken, runouts_checked, error_results);
      $display("decks from empty to full, deals 0 to 7, %0d runout_count writes from 0 to 15",
               csr_writes);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
